// ----- src/mwf_pkg.sv -----
// shared codes, field widths and reset values of the maze wall follower
package mwf_pkg;

   // field widths fixed by the interface
   localparam int CELL_W     = 4;
   localparam int HEAD_W     = 2;
   localparam int STAT_W     = 2;
   localparam int CMD_W      = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 4;

   typedef logic [CMD_W-1:0]     cmd_type;
   typedef logic [STAT_W-1:0]    status_type;
   typedef logic [HEAD_W-1:0]    dir_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   // item commands
   localparam cmd_type CMD_WRITE   = 2'd0;
   localparam cmd_type CMD_RESTART = 2'd1;
   localparam cmd_type CMD_STEP    = 2'd2;

   // walk status codes
   localparam status_type ST_RUNNING  = 2'd0;
   localparam status_type ST_EXITED   = 2'd1;
   localparam status_type ST_RETURNED = 2'd2;
   localparam status_type ST_STUCK    = 2'd3;

   // headings
   localparam dir_type DIR_DOWN  = 2'd0;
   localparam dir_type DIR_RIGHT = 2'd1;
   localparam dir_type DIR_UP    = 2'd2;
   localparam dir_type DIR_LEFT  = 2'd3;

   // configuration register indexes
   localparam csr_idx_type REG_START_ROW  = 2'd0;
   localparam csr_idx_type REG_START_COL  = 2'd1;
   localparam csr_idx_type REG_START_HEAD = 2'd2;

   // reset values of the start registers
   localparam logic [CELL_W-1:0] START_ROW_RST  = 4'd2;
   localparam logic [CELL_W-1:0] START_COL_RST  = 4'd0;
   localparam dir_type           START_HEAD_RST = DIR_RIGHT;

endpackage

// ----- src/mwf_ram.sv -----
// generic single-write, single-read ram with registered read data
module mwf_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, old data on a same-address write
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/mwf_nbr.sv -----
// neighbor cell addresses and on-grid flags for the four headings of a position
module mwf_nbr #(
   parameter int GRID_SIZE = 16,
   parameter int PW        = 4,
   parameter int AW        = 8
) (
   input  logic [PW-1:0]         row,
   input  logic [PW-1:0]         col,
   output logic [3:0][AW-1:0]    nbr_addr,
   output logic [3:0]            nbr_ok
);

   localparam int MW = AW + PW + 2;

   logic [3:0][PW:0] nbr_row;
   logic [3:0][PW:0] nbr_col;
   logic [3:0]       no_wrap;
   logic [3:0][MW-1:0] prod;

   // neighbor coordinates, one bit wider so a step past the grid shows
   always_comb begin
      nbr_row[mwf_pkg::DIR_DOWN]  = {1'b0, row} + (PW+1)'(1);
      nbr_col[mwf_pkg::DIR_DOWN]  = {1'b0, col};
      no_wrap[mwf_pkg::DIR_DOWN]  = 1'b1;
      nbr_row[mwf_pkg::DIR_RIGHT] = {1'b0, row};
      nbr_col[mwf_pkg::DIR_RIGHT] = {1'b0, col} + (PW+1)'(1);
      no_wrap[mwf_pkg::DIR_RIGHT] = 1'b1;
      nbr_row[mwf_pkg::DIR_UP]    = {1'b0, row} - (PW+1)'(1);
      nbr_col[mwf_pkg::DIR_UP]    = {1'b0, col};
      no_wrap[mwf_pkg::DIR_UP]    = (row != '0);
      nbr_row[mwf_pkg::DIR_LEFT]  = {1'b0, row};
      nbr_col[mwf_pkg::DIR_LEFT]  = {1'b0, col} - (PW+1)'(1);
      no_wrap[mwf_pkg::DIR_LEFT]  = (col != '0);
   end

   // flat address row * size + col, and the on-grid test
   always_comb begin
      for (int d = 0; d < 4; d++) begin
         prod[d]     = MW'(nbr_row[d]) * MW'(GRID_SIZE) + MW'(nbr_col[d]);
         nbr_addr[d] = prod[d][AW-1:0];
         nbr_ok[d]   = no_wrap[d]
                     && (nbr_row[d] < (PW+1)'(GRID_SIZE))
                     && (nbr_col[d] < (PW+1)'(GRID_SIZE));
      end
   end

endmodule

// ----- src/maze_wall_follower.sv -----
// top level of the maze wall follower: state, step logic and wall map rams
//
// Usage
//   Request beats (req_*) carry one command: write a wall bit of one cell,
//   restart the walker at the start cell and heading, or take one step.
//   Every request beat yields exactly one response beat (rsp_*) holding the
//   walker position, heading and walk status after that command.
//   The start cell and heading are written on the csr_* port while the
//   block is idle; they take effect at the next restart.
//   The response is valid in the cycle after its request is accepted, and one
//   request is taken every cycle while the response is not stalled. The four
//   wall map rams allow this: each holds a copy of the map and is read at one
//   neighbor of the position the walker will stand on next, so the read data
//   are ready when the following step arrives.
//   A stalled response holds; a new request is taken in the cycle the held
//   response leaves, and req_stall stays high while it cannot.
//   Reset loads the default start cell, heading and running status and empties
//   the response register; the wall map keeps no reset value, so the user must
//   write every cell before the walker steps next to it, which is not enforced.
module maze_wall_follower #(
   parameter int GRID_SIZE = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [mwf_pkg::CMD_W-1:0]           req_cmd,
   input  logic [mwf_pkg::CELL_W-1:0]          req_cell_row,
   input  logic [mwf_pkg::CELL_W-1:0]          req_cell_col,
   input  logic                                req_is_wall,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [mwf_pkg::CELL_W-1:0]          rsp_pos_row,
   output logic [mwf_pkg::CELL_W-1:0]          rsp_pos_col,
   output logic [mwf_pkg::HEAD_W-1:0]          rsp_heading,
   output logic [mwf_pkg::STAT_W-1:0]          rsp_walk_status,
   // configuration write port
   input  logic                                csr_wr_en,
   input  logic [mwf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mwf_pkg::CSR_DATA_W-1:0]      csr_wr_data
);

   localparam int PW = ($clog2(GRID_SIZE) > mwf_pkg::CELL_W)
                     ? $clog2(GRID_SIZE) : mwf_pkg::CELL_W;
   localparam int DEPTH = GRID_SIZE * GRID_SIZE;
   localparam int AW    = $clog2(DEPTH);
   localparam int MW    = AW + PW + 2;

   logic [mwf_pkg::CELL_W-1:0] start_row_ff;
   logic [mwf_pkg::CELL_W-1:0] start_col_ff;
   mwf_pkg::dir_type           start_head_ff;

   logic [PW-1:0]          cur_row_ff, cur_row_in;
   logic [PW-1:0]          cur_col_ff, cur_col_in;
   mwf_pkg::dir_type       cur_head_ff, cur_head_in;
   mwf_pkg::status_type    status_ff, status_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic                   accept;
   logic                   wr_en;
   logic [MW-1:0]          wr_prod;
   logic [AW-1:0]          wr_addr;

   logic [PW-1:0]          look_row;
   logic [PW-1:0]          look_col;
   logic [3:0][AW-1:0]     nbr_addr;
   logic [3:0]             nbr_ok;
   logic [3:0]             rd_bit;
   logic [3:0]             ok_ff;
   logic [3:0]             hit_ff;
   logic                   wbit_ff;
   logic [3:0]             wall_dir;
   logic [3:0]             open_dir;

   logic                   found;
   mwf_pkg::dir_type       mv_dir;
   mwf_pkg::dir_type       try_dir;
   logic [PW-1:0]          mv_row;
   logic [PW-1:0]          mv_col;
   logic                   mv_edge;

   // handshake
   assign req_stall = reset | (rsp_valid_ff & rsp_stall);
   assign accept    = req_valid & ~req_stall;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_row_ff  <= mwf_pkg::START_ROW_RST;
         start_col_ff  <= mwf_pkg::START_COL_RST;
         start_head_ff <= mwf_pkg::START_HEAD_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            mwf_pkg::REG_START_ROW:  start_row_ff  <= csr_wr_data;
            mwf_pkg::REG_START_COL:  start_col_ff  <= csr_wr_data;
            mwf_pkg::REG_START_HEAD: start_head_ff <= csr_wr_data[mwf_pkg::HEAD_W-1:0];
            default: ;
         endcase
      end
   end

   // wall write address; writes off the grid are dropped
   assign wr_prod = MW'(req_cell_row) * MW'(GRID_SIZE) + MW'(req_cell_col);
   assign wr_addr = wr_prod[AW-1:0];
   assign wr_en   = accept && (req_cmd == mwf_pkg::CMD_WRITE)
                 && (MW'(req_cell_row) < MW'(GRID_SIZE))
                 && (MW'(req_cell_col) < MW'(GRID_SIZE));

   // look ahead at the neighbors of the position held after this edge
   assign look_row = reset ? PW'(mwf_pkg::START_ROW_RST) : cur_row_in;
   assign look_col = reset ? PW'(mwf_pkg::START_COL_RST) : cur_col_in;

   mwf_nbr #(
      .GRID_SIZE (GRID_SIZE),
      .PW        (PW),
      .AW        (AW)
   ) u_nbr (
      .row      (look_row),
      .col      (look_col),
      .nbr_addr (nbr_addr),
      .nbr_ok   (nbr_ok)
   );

   // one map copy per heading, each read at its own neighbor
   for (genvar d = 0; d < 4; d++) begin : g_map
      mwf_ram #(
         .WIDTH (1),
         .DEPTH (DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (wr_addr),
         .wr_data (req_is_wall),
         .rd_addr (nbr_addr[d]),
         .rd_data (rd_bit[d:d])
      );
   end

   // on-grid flags and write bypass for the ram read in flight
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= '0;
      end else begin
         for (int d = 0; d < 4; d++) begin
            hit_ff[d] <= wr_en && (wr_addr == nbr_addr[d]);
         end
      end
      ok_ff   <= nbr_ok;
      wbit_ff <= req_is_wall;
   end

   assign wall_dir = (hit_ff & {4{wbit_ff}}) | (~hit_ff & rd_bit);
   assign open_dir = ok_ff & ~wall_dir;

   // first open heading, trying heading, +1, +2, +3
   always_comb begin
      found  = 1'b0;
      mv_dir = cur_head_ff;
      for (int k = 0; k < 4; k++) begin
         try_dir = cur_head_ff + mwf_pkg::dir_type'(k);
         if (!found && open_dir[try_dir]) begin
            found  = 1'b1;
            mv_dir = try_dir;
         end
      end
   end

   // target cell of the move
   always_comb begin
      mv_row = cur_row_ff;
      mv_col = cur_col_ff;
      unique case (mv_dir)
         mwf_pkg::DIR_DOWN:  mv_row = cur_row_ff + PW'(1);
         mwf_pkg::DIR_RIGHT: mv_col = cur_col_ff + PW'(1);
         mwf_pkg::DIR_UP:    mv_row = cur_row_ff - PW'(1);
         mwf_pkg::DIR_LEFT:  mv_col = cur_col_ff - PW'(1);
         default: ;
      endcase
      mv_edge = (mv_row == '0) || (mv_col == '0)
             || (mv_row == PW'(GRID_SIZE - 1)) || (mv_col == PW'(GRID_SIZE - 1));
   end

   // walker next state
   always_comb begin
      cur_row_in  = cur_row_ff;
      cur_col_in  = cur_col_ff;
      cur_head_in = cur_head_ff;
      status_in   = status_ff;
      if (accept) begin
         unique case (req_cmd)
            mwf_pkg::CMD_RESTART: begin
               cur_row_in  = PW'(start_row_ff);
               cur_col_in  = PW'(start_col_ff);
               cur_head_in = start_head_ff;
               status_in   = mwf_pkg::ST_RUNNING;
            end
            mwf_pkg::CMD_STEP: begin
               if (status_ff == mwf_pkg::ST_RUNNING) begin
                  if (found) begin
                     cur_row_in  = mv_row;
                     cur_col_in  = mv_col;
                     cur_head_in = mv_dir + mwf_pkg::dir_type'(3);
                     if (mv_row == PW'(start_row_ff) && mv_col == PW'(start_col_ff)) begin
                        status_in = mwf_pkg::ST_RETURNED;
                     end else if (mv_edge) begin
                        status_in = mwf_pkg::ST_EXITED;
                     end else begin
                        status_in = mwf_pkg::ST_RUNNING;
                     end
                  end else begin
                     status_in = mwf_pkg::ST_STUCK;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // response beat valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // walker state, which is also the response payload
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_row_ff   <= PW'(mwf_pkg::START_ROW_RST);
         cur_col_ff   <= PW'(mwf_pkg::START_COL_RST);
         cur_head_ff  <= mwf_pkg::START_HEAD_RST;
         status_ff    <= mwf_pkg::ST_RUNNING;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         cur_head_ff  <= cur_head_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pos_row     = cur_row_ff[mwf_pkg::CELL_W-1:0];
   assign rsp_pos_col     = cur_col_ff[mwf_pkg::CELL_W-1:0];
   assign rsp_heading     = cur_head_ff;
   assign rsp_walk_status = status_ff;

endmodule

// ----- src/mwf_chk.sv -----
// port-level checker of the maze wall follower and its bind
module mwf_chk (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic [mwf_pkg::CMD_W-1:0]      req_cmd,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [mwf_pkg::CELL_W-1:0]     rsp_pos_row,
   input logic [mwf_pkg::CELL_W-1:0]     rsp_pos_col,
   input logic [mwf_pkg::HEAD_W-1:0]     rsp_heading,
   input logic [mwf_pkg::STAT_W-1:0]     rsp_walk_status
);

   logic req_beat;

   assign req_beat = req_valid && !req_stall;

   // nothing is offered right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a held response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pos_row)
         && $stable(rsp_pos_col) && $stable(rsp_heading) && $stable(rsp_walk_status))
      else $error("stalled response changed");

   // a restart always reports a running walk
   a_restart_runs: assert property (@(posedge clock) disable iff (reset)
      req_beat && req_cmd == mwf_pkg::CMD_RESTART
         |=> rsp_valid && rsp_walk_status == mwf_pkg::ST_RUNNING)
      else $error("restart did not report a running walk");

   // a step after the walk has ended leaves the walker alone
   a_ended_step: assert property (@(posedge clock) disable iff (reset)
      req_beat && req_cmd == mwf_pkg::CMD_STEP && rsp_walk_status != mwf_pkg::ST_RUNNING
         |=> $stable(rsp_pos_row) && $stable(rsp_pos_col)
            && $stable(rsp_heading) && $stable(rsp_walk_status))
      else $error("step moved an ended walk");

   // a cell write never moves the walker
   a_write_still: assert property (@(posedge clock) disable iff (reset)
      req_beat && req_cmd == mwf_pkg::CMD_WRITE
         |=> rsp_valid && $stable(rsp_pos_row) && $stable(rsp_pos_col)
            && $stable(rsp_heading) && $stable(rsp_walk_status))
      else $error("cell write changed the walker");

endmodule

bind maze_wall_follower mwf_chk u_mwf_chk (.*);

// ----- bench/tb_top.sv -----
// self-checking testbench of the maze wall follower with a built-in walker predictor
`timescale 1ns / 1ps

module tb_top;

   localparam int GRID        = 16;
   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 150;
   localparam int PHASE_ITEMS = 100;

   typedef logic [mwf_pkg::CELL_W-1:0]     cell_type;
   typedef logic [mwf_pkg::CSR_DATA_W-1:0] csr_data_type;

   // codes the package leaves unnamed
   localparam mwf_pkg::cmd_type     CMD_UNUSED = 2'd3;
   localparam mwf_pkg::csr_idx_type REG_UNUSED = 2'd3;

   // walker position, heading and status carried by one response beat
   typedef struct packed {
      cell_type            pos_row;
      cell_type            pos_col;
      mwf_pkg::dir_type    heading;
      mwf_pkg::status_type walk_status;
   } walker_report_type;

   // walker predictor plus the queue of reports still owed by the block
   class walker_scoreboard;
      bit                  wall [GRID][GRID];
      cell_type            row;
      cell_type            col;
      mwf_pkg::dir_type    head;
      mwf_pkg::status_type status;
      cell_type            start_row;
      cell_type            start_col;
      mwf_pkg::dir_type    start_head;
      walker_report_type   pending [$];
      int unsigned         errors;

      function new();
         start_row  = mwf_pkg::START_ROW_RST;
         start_col  = mwf_pkg::START_COL_RST;
         start_head = mwf_pkg::START_HEAD_RST;
         row        = start_row;
         col        = start_col;
         head       = start_head;
         status     = mwf_pkg::ST_RUNNING;
         errors     = 0;
      endfunction

      function void set_register(mwf_pkg::csr_idx_type idx, csr_data_type data);
         case (idx)
            mwf_pkg::REG_START_ROW:  start_row  = data;
            mwf_pkg::REG_START_COL:  start_col  = data;
            mwf_pkg::REG_START_HEAD: start_head = data[mwf_pkg::HEAD_W-1:0];
            default: ;
         endcase
      endfunction

      // cell next to the walker in direction d; returns 0 when off the grid
      function bit neighbour(mwf_pkg::dir_type d, output int nr, output int nc);
         nr = int'(row);
         nc = int'(col);
         case (d)
            mwf_pkg::DIR_DOWN:  nr = nr + 1;
            mwf_pkg::DIR_RIGHT: nc = nc + 1;
            mwf_pkg::DIR_UP:    nr = nr - 1;
            default:            nc = nc - 1;
         endcase
         return nr >= 0 && nc >= 0 && nr < GRID && nc < GRID;
      endfunction

      // try heading, heading+1, +2, +3 and move to the first open cell
      function void step_walker();
         int               nr;
         int               nc;
         mwf_pkg::dir_type d;
         if (status != mwf_pkg::ST_RUNNING)
            return;
         for (int k = 0; k < 4; k++) begin
            d = head + mwf_pkg::dir_type'(k);
            if (neighbour(d, nr, nc) && !wall[nr][nc]) begin
               row  = nr[mwf_pkg::CELL_W-1:0];
               col  = nc[mwf_pkg::CELL_W-1:0];
               head = d + mwf_pkg::dir_type'(3);
               if (row == start_row && col == start_col)
                  status = mwf_pkg::ST_RETURNED;
               else if (row == 0 || col == 0 || row == GRID - 1 || col == GRID - 1)
                  status = mwf_pkg::ST_EXITED;
               else
                  status = mwf_pkg::ST_RUNNING;
               return;
            end
         end
         status = mwf_pkg::ST_STUCK;
      endfunction

      // accepted request beat: update the walker and queue its report
      function void note_command(mwf_pkg::cmd_type cmd, cell_type r, cell_type c, logic w);
         walker_report_type rep;
         case (cmd)
            mwf_pkg::CMD_WRITE: wall[r][c] = w;
            mwf_pkg::CMD_RESTART: begin
               row    = start_row;
               col    = start_col;
               head   = start_head;
               status = mwf_pkg::ST_RUNNING;
            end
            mwf_pkg::CMD_STEP: step_walker();
            default: ;
         endcase
         rep.pos_row     = row;
         rep.pos_col     = col;
         rep.heading     = head;
         rep.walk_status = status;
         pending.push_back(rep);
      endfunction

      // accepted response beat against the oldest owed report
      function void check_report(walker_report_type got);
         walker_report_type want;
         if (pending.size() == 0) begin
            $error("response beat with no request outstanding");
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.pos_row !== want.pos_row) begin
            $error("pos_row expected %0d actual %0d", want.pos_row, got.pos_row);
            errors++;
         end
         if (got.pos_col !== want.pos_col) begin
            $error("pos_col expected %0d actual %0d", want.pos_col, got.pos_col);
            errors++;
         end
         if (got.heading !== want.heading) begin
            $error("heading expected %0d actual %0d", want.heading, got.heading);
            errors++;
         end
         if (got.walk_status !== want.walk_status) begin
            $error("walk_status expected %0d actual %0d", want.walk_status,
                   got.walk_status);
            errors++;
         end
      endfunction
   endclass

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_stall;
   mwf_pkg::cmd_type                  req_cmd;
   cell_type                          req_cell_row;
   cell_type                          req_cell_col;
   logic                              req_is_wall;
   logic                              rsp_valid;
   logic                              rsp_stall;
   cell_type                          rsp_pos_row;
   cell_type                          rsp_pos_col;
   logic [mwf_pkg::HEAD_W-1:0]        rsp_heading;
   logic [mwf_pkg::STAT_W-1:0]        rsp_walk_status;
   logic                              csr_wr_en;
   mwf_pkg::csr_idx_type              csr_index;
   csr_data_type                      csr_wr_data;

   walker_scoreboard sb;
   bit               idle_on;
   bit               pressure_go;
   int               wall_pct;
   int               quiet_cycles;

   maze_wall_follower #(.GRID_SIZE(GRID)) i_dut (.*);

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // response side: random stall bursts and one long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (pressure_go) begin
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall   = 1'b0;
            pressure_go = 1'b0;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 18)) @(negedge clock);
            rsp_stall = 1'b0;
         end
      end
   end

   // check every accepted response beat
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         sb.check_report({rsp_pos_row, rsp_pos_col, rsp_heading, rsp_walk_status});
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if (reset || (req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[maze_wall_follower] ERROR");
         $finish;
      end
   end

   // one request beat, then maybe a random idle burst
   task automatic issue(input mwf_pkg::cmd_type cmd, input cell_type r,
                        input cell_type c, input logic w);
      @(negedge clock);
      req_valid    = 1'b1;
      req_cmd      = cmd;
      req_cell_row = r;
      req_cell_col = c;
      req_is_wall  = w;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_command(cmd, r, c, w);
      if (idle_on && $urandom_range(0, 7) == 0) begin
         @(negedge clock) req_valid = 1'b0;
         repeat ($urandom_range(0, 17)) @(negedge clock);
      end
   endtask

   // wait until every owed report has come back and the block is quiet
   task automatic drain();
      @(negedge clock) req_valid = 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input mwf_pkg::csr_idx_type idx, input csr_data_type data);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_index   = idx;
      csr_wr_data = data;
      @(posedge clock);
      sb.set_register(idx, data);
      @(negedge clock) csr_wr_en = 1'b0;
   endtask

   task automatic set_start(input cell_type r, input cell_type c, input csr_data_type h);
      drain();
      csr_write(mwf_pkg::REG_START_ROW, r);
      csr_write(mwf_pkg::REG_START_COL, c);
      csr_write(mwf_pkg::REG_START_HEAD, h);
   endtask

   // write every cell of the grid
   task automatic load_map(input int pct);
      for (int r = 0; r < GRID; r++)
         for (int c = 0; c < GRID; c++)
            issue(mwf_pkg::CMD_WRITE, r[mwf_pkg::CELL_W-1:0], c[mwf_pkg::CELL_W-1:0],
                  $urandom_range(0, 99) < pct);
   endtask

   // mostly walks restarted once ended, with wall edits near the walker
   task automatic run_walks(input int n);
      int       nr;
      int       nc;
      int       roll;
      cell_type r;
      cell_type c;
      for (int i = 0; i < n; i++) begin
         roll = $urandom_range(0, 99);
         r    = cell_type'($urandom_range(0, GRID - 1));
         c    = cell_type'($urandom_range(0, GRID - 1));
         if ((sb.status != mwf_pkg::ST_RUNNING && roll < 60) || roll < 4)
            issue(mwf_pkg::CMD_RESTART, r, c, 1'($urandom_range(0, 1)));
         else if (roll < 8)
            issue(CMD_UNUSED, r, c, 1'($urandom_range(0, 1)));
         else if (roll < 40) begin
            if (roll < 26 && sb.neighbour(mwf_pkg::dir_type'($urandom_range(0, 3)), nr, nc))
            begin
               r = nr[mwf_pkg::CELL_W-1:0];
               c = nc[mwf_pkg::CELL_W-1:0];
            end
            issue(mwf_pkg::CMD_WRITE, r, c, $urandom_range(0, 99) < wall_pct);
         end else
            issue(mwf_pkg::CMD_STEP, r, c, 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic run_phase(input cell_type r, input cell_type c, input csr_data_type h,
                            input bit idle, input int n);
      set_start(r, c, h);
      idle_on  = idle;
      wall_pct = $urandom_range(15, 40);
      issue(mwf_pkg::CMD_RESTART, c, r, 1'b0);
      run_walks(n);
   endtask

   // main sequence
   initial begin
      sb           = new();
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_cmd      = mwf_pkg::CMD_WRITE;
      req_cell_row = '0;
      req_cell_col = '0;
      req_is_wall  = 1'b0;
      csr_wr_en    = 1'b0;
      csr_index    = mwf_pkg::REG_START_ROW;
      csr_wr_data  = '0;
      idle_on      = 1'b1;
      pressure_go  = 1'b0;
      wall_pct     = 30;
      quiet_cycles = 0;
      repeat (8) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      // unused command and restart are safe before the map is loaded
      issue(CMD_UNUSED, 4'd15, 4'd15, 1'b1);
      issue(mwf_pkg::CMD_RESTART, 4'd0, 4'd0, 1'b0);
      load_map(0);

      // default start on an open map, then the unused command mid-walk
      issue(mwf_pkg::CMD_STEP, 4'd0, 4'd0, 1'b0);
      issue(mwf_pkg::CMD_STEP, 4'd15, 4'd15, 1'b1);
      issue(CMD_UNUSED, 4'd0, 4'd0, 1'b0);

      // corner start: first open move lands on an edge, later step is frozen
      set_start(4'd15, 4'd15, {2'b00, mwf_pkg::DIR_DOWN});
      issue(mwf_pkg::CMD_RESTART, 4'd0, 4'd0, 1'b0);
      issue(mwf_pkg::CMD_STEP, 4'd0, 4'd0, 1'b0);
      issue(mwf_pkg::CMD_STEP, 4'd0, 4'd0, 1'b0);

      // walled-in corner: stuck, then frozen
      set_start(4'd0, 4'd0, {2'b00, mwf_pkg::DIR_LEFT});
      issue(mwf_pkg::CMD_WRITE, 4'd1, 4'd0, 1'b1);
      issue(mwf_pkg::CMD_WRITE, 4'd0, 4'd1, 1'b1);
      issue(mwf_pkg::CMD_RESTART, 4'd0, 4'd0, 1'b0);
      issue(mwf_pkg::CMD_STEP, 4'd0, 4'd0, 1'b0);
      issue(mwf_pkg::CMD_STEP, 4'd0, 4'd0, 1'b0);

      // dead end below an interior start: walker comes back to the start
      set_start(4'd5, 4'd5, {2'b00, mwf_pkg::DIR_DOWN});
      issue(mwf_pkg::CMD_WRITE, 4'd6, 4'd4, 1'b1);
      issue(mwf_pkg::CMD_WRITE, 4'd7, 4'd5, 1'b1);
      issue(mwf_pkg::CMD_WRITE, 4'd6, 4'd6, 1'b1);
      issue(mwf_pkg::CMD_RESTART, 4'd0, 4'd0, 1'b0);
      issue(mwf_pkg::CMD_STEP, 4'd0, 4'd0, 1'b0);
      issue(mwf_pkg::CMD_STEP, 4'd0, 4'd0, 1'b0);
      issue(mwf_pkg::CMD_STEP, 4'd0, 4'd0, 1'b0);

      // random maze, then walks under several start settings
      load_map(30);
      run_phase(4'd0, 4'd0, {2'b00, mwf_pkg::DIR_DOWN}, 1'b1, PHASE_ITEMS);
      run_phase(4'd15, 4'd15, {2'b11, mwf_pkg::DIR_LEFT}, 1'b0, PHASE_ITEMS);
      run_phase(4'd15, 4'd0, {2'b10, mwf_pkg::DIR_UP}, 1'b1, PHASE_ITEMS);
      run_phase(4'd0, 4'd15, {2'b01, mwf_pkg::DIR_RIGHT}, 1'b1, PHASE_ITEMS);
      run_phase(cell_type'($urandom_range(0, 15)), cell_type'($urandom_range(0, 15)),
                csr_data_type'($urandom_range(0, 15)), 1'b1, PHASE_ITEMS);

      // unmapped register index, then a long response hold-off while beats pile up
      drain();
      csr_write(REG_UNUSED, csr_data_type'($urandom_range(0, 15)));
      pressure_go = 1'b1;
      run_phase(cell_type'($urandom_range(0, 15)), cell_type'($urandom_range(0, 15)),
                csr_data_type'($urandom_range(0, 15)), 1'b1, PHASE_ITEMS);

      // closing stretch at the reset start, no idling on either side
      run_phase(mwf_pkg::START_ROW_RST, mwf_pkg::START_COL_RST,
                {2'b00, mwf_pkg::START_HEAD_RST}, 1'b0, PHASE_ITEMS);

      drain();
      if (sb.errors == 0)
         $display("[maze_wall_follower] OK");
      else
         $display("[maze_wall_follower] ERROR");
      $finish;
   end

endmodule
